FILE: hw/rtl/ssm_pkg.sv
// Shared types, codes and conversion helpers of the stereo sample mixer.
package ssm_pkg;

	localparam int PAINT_DEPTH_DEF = 2048;

	localparam int CFG_DATA_W  = 10;
	localparam int CFG_INDEX_W = 2;

	localparam logic [9:0] MASTER_MAX   = 10'd512;
	localparam logic [8:0] VOL8_MAX     = 9'd255;
	localparam logic [4:0] RING_LOG_MIN = 5'd1;
	localparam logic [4:0] RING_LOG_MAX = 5'd16;

	localparam logic [9:0] MASTER_RST    = 10'd256;
	localparam logic [1:0] CHANNELS_RST  = 2'd2;
	localparam logic       SIXTEEN_RST   = 1'b1;
	localparam logic [4:0] RING_LOG_RST  = 5'd14;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_ADD8  = 2'd1,
		ACT_ADD16 = 2'd2,
		ACT_XFER  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_MASTER   = 2'd0,
		CFG_CHANNELS = 2'd1,
		CFG_SIXTEEN  = 2'd2,
		CFG_RING_LOG = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_ADD
	} state_t;

	typedef struct packed {
		logic [15:0] value;
		logic [15:0] address;
		logic        last;
	} result_t;

	// Scale a sum down by 256, saturate to 16 bits, optionally pack as offset-binary byte
	function automatic logic [15:0] convert(input logic [31:0] sum, input logic sixteen);
		logic signed [23:0] v;
		logic signed [15:0] s;
		v = $signed(sum[31:8]);
		if (v > 24'sd32767) begin
			s = 16'sh7fff;
		end else if (v < -24'sd32768) begin
			s = 16'sh8000;
		end else begin
			s = 16'(v);
		end
		if (sixteen) begin
			return s;
		end
		return {8'h00, s[15:8] ^ 8'h80};
	endfunction

endpackage

FILE: hw/rtl/ssm_out_buf.sv
// Two-entry result buffer that holds the samples of one transfer until taken.
module ssm_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  push_two,
	input  ssm_pkg::result_t      res_first,
	input  ssm_pkg::result_t      res_second,
	output logic                  empty,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    out_value,
	output logic [15:0]           ring_address,
	output logic                  last
);

	ssm_pkg::result_t ent0_q;
	ssm_pkg::result_t ent1_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign empty     = (cnt_q == 2'd0);
	assign out_valid = !empty;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= push_two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Advance the second sample to the head once the first is taken
	always_ff @(posedge clk) begin
		if (push) begin
			ent0_q <= res_first;
			ent1_q <= res_second;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
	end

	assign out_value    = $signed(ent0_q.value);
	assign ring_address = ent0_q.address;
	assign last         = ent0_q.last;

endmodule

FILE: hw/rtl/stereo_sample_mixer_unit.sv
// Load: the paint memory is written on accept; the mixer takes the next item in the following cycle.
// Add (8-bit or 16-bit): accept, memory read and gain multiply, sample multiply,
// write back, as a single memory read-modify-write; no new item is taken before write back.
// Transfer: the first result is registered in the result buffer; waits while the result buffer holds samples.
// Reset clears control, ring pointer and registers to their defaults;
// the paint memory is not cleared and holds no valid data until written.
module stereo_sample_mixer_unit #(
	parameter int PAINT_DEPTH = ssm_pkg::PAINT_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [ssm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [10:0]                     slot,
	input  logic signed [15:0]              sample,
	input  logic [8:0]                      left_volume,
	input  logic [8:0]                      right_volume,
	input  logic signed [31:0]              load_left,
	input  logic signed [31:0]              load_right,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [15:0]              out_value,
	output logic [15:0]                     ring_address,
	output logic                            last
);

	// Depth is a power of two: the slot wraps by truncation
	localparam int AW = $clog2(PAINT_DEPTH);

	logic [31:0] paint_left  [PAINT_DEPTH];
	logic [31:0] paint_right [PAINT_DEPTH];

	ssm_pkg::state_t state_q, state_d;

	logic [9:0]  master_q;
	logic [1:0]  chans_q;
	logic        sixteen_q;
	logic [4:0]  ring_log_q;
	logic [15:0] ring_ptr_q;

	logic [1:0]        act_q;
	logic [AW-1:0]     idx_q;
	logic [15:0]       sample_q;
	logic [8:0]        lvol_q;
	logic [8:0]        rvol_q;
	logic [31:0]       rd_left_q;
	logic [31:0]       rd_right_q;
	logic [18:0]       gain_l_q;
	logic [18:0]       gain_r_q;
	logic [31:0]       delta_l_q;
	logic [31:0]       delta_r_q;

	ssm_pkg::action_t  act;
	logic              accept;
	logic              rd_en;
	logic              wr_en;
	logic              push;
	logic              ob_empty;
	logic [AW-1:0]     in_idx;
	logic [AW-1:0]     wr_idx;
	logic [31:0]       wr_left;
	logic [31:0]       wr_right;
	logic [9:0]        master_cl;
	logic              two;
	logic [4:0]        ring_log_cl;
	logic [15:0]       ring_mask;
	logic [18:0]       gain_l;
	logic [18:0]       gain_r;
	logic [8:0]        j_raw;
	logic signed [16:0] mcand;
	logic signed [36:0] prod_l;
	logic signed [36:0] prod_r;
	logic [31:0]       delta_l;
	logic [31:0]       delta_r;
	ssm_pkg::result_t  res_first;
	ssm_pkg::result_t  res_second;

	function automatic logic [8:0] sel_vol(input logic [8:0] vol, input logic eight);
		logic [8:0] v;
		v = (vol > ssm_pkg::VOL8_MAX) ? ssm_pkg::VOL8_MAX : vol;
		return eight ? {v[8:3], 3'b000} : vol;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q   <= ssm_pkg::MASTER_RST;
			chans_q    <= ssm_pkg::CHANNELS_RST;
			sixteen_q  <= ssm_pkg::SIXTEEN_RST;
			ring_log_q <= ssm_pkg::RING_LOG_RST;
		end else if (cfg_write_en) begin
			case (ssm_pkg::cfg_index_t'(cfg_index))
				ssm_pkg::CFG_MASTER:   master_q   <= cfg_data;
				ssm_pkg::CFG_CHANNELS: chans_q    <= cfg_data[1:0];
				ssm_pkg::CFG_SIXTEEN:  sixteen_q  <= cfg_data[0];
				ssm_pkg::CFG_RING_LOG: ring_log_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign master_cl   = (master_q > ssm_pkg::MASTER_MAX) ? ssm_pkg::MASTER_MAX : master_q;
	assign two         = chans_q[1];
	assign ring_log_cl = (ring_log_q < ssm_pkg::RING_LOG_MIN) ? ssm_pkg::RING_LOG_MIN :
	                     (ring_log_q > ssm_pkg::RING_LOG_MAX) ? ssm_pkg::RING_LOG_MAX : ring_log_q;
	assign ring_mask   = 16'((17'd1 << ring_log_cl) - 17'd1);

	assign act    = ssm_pkg::action_t'(act_q);
	assign accept = in_valid && in_ready;
	assign in_idx = AW'(slot);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		push     = 1'b0;
		case (state_q)
			ssm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (ssm_pkg::action_t'(action) == ssm_pkg::ACT_LOAD) begin
						wr_en = 1'b1;
					end else begin
						rd_en   = 1'b1;
						state_d = ssm_pkg::ST_READ;
					end
				end
			end
			ssm_pkg::ST_READ: begin
				if (act == ssm_pkg::ACT_XFER) begin
					// Hold until the buffer has drained the previous transfer
					if (ob_empty) begin
						push    = 1'b1;
						state_d = ssm_pkg::ST_IDLE;
					end
				end else begin
					state_d = ssm_pkg::ST_MUL;
				end
			end
			ssm_pkg::ST_MUL: begin
				state_d = ssm_pkg::ST_ADD;
			end
			ssm_pkg::ST_ADD: begin
				wr_en   = 1'b1;
				state_d = ssm_pkg::ST_IDLE;
			end
			default: begin
				state_d = ssm_pkg::ST_IDLE;
			end
		endcase
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			idx_q    <= in_idx;
			sample_q <= sample;
			lvol_q   <= left_volume;
			rvol_q   <= right_volume;
		end
	end

	// Paint memory: one synchronous read, one write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_left_q  <= paint_left[in_idx];
			rd_right_q <= paint_right[in_idx];
		end
		if (wr_en) begin
			paint_left[wr_idx]  <= wr_left;
			paint_right[wr_idx] <= wr_right;
		end
	end

	assign wr_idx   = (state_q == ssm_pkg::ST_IDLE) ? in_idx : idx_q;
	assign wr_left  = (state_q == ssm_pkg::ST_IDLE) ? load_left  : rd_left_q  + delta_l_q;
	assign wr_right = (state_q == ssm_pkg::ST_IDLE) ? load_right : rd_right_q + delta_r_q;

	// Gain: volume times master, volume clamped and stepped by 8 for byte samples
	assign gain_l = 19'(sel_vol(lvol_q, act == ssm_pkg::ACT_ADD8)) * 19'(master_cl);
	assign gain_r = 19'(sel_vol(rvol_q, act == ssm_pkg::ACT_ADD8)) * 19'(master_cl);

	// Byte sample: values from 128 up map to byte minus 255
	assign j_raw  = {1'b0, sample_q[7:0]} - (sample_q[7] ? 9'd255 : 9'd0);
	assign mcand  = (act == ssm_pkg::ACT_ADD8) ? 17'($signed(j_raw)) : 17'($signed(sample_q));
	assign prod_l = mcand * $signed({1'b0, gain_l_q});
	assign prod_r = mcand * $signed({1'b0, gain_r_q});
	assign delta_l = (act == ssm_pkg::ACT_ADD16) ? 32'(prod_l >>> 8) : 32'(prod_l);
	assign delta_r = (act == ssm_pkg::ACT_ADD16) ? 32'(prod_r >>> 8) : 32'(prod_r);

	always_ff @(posedge clk) begin
		if (state_q == ssm_pkg::ST_READ) begin
			gain_l_q <= gain_l;
			gain_r_q <= gain_r;
		end
		if (state_q == ssm_pkg::ST_MUL) begin
			delta_l_q <= delta_l;
			delta_r_q <= delta_r;
		end
	end

	// Transfer results
	always_comb begin
		res_first.value    = ssm_pkg::convert(rd_left_q, sixteen_q);
		res_first.address  = ring_ptr_q & ring_mask;
		res_first.last     = !two;
		res_second.value   = ssm_pkg::convert(rd_right_q, sixteen_q);
		res_second.address = (ring_ptr_q + 16'd1) & ring_mask;
		res_second.last    = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_ptr_q <= 16'd0;
		end else if (push) begin
			ring_ptr_q <= ring_ptr_q + (two ? 16'd2 : 16'd1);
		end
	end

	ssm_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_two     (two),
		.res_first    (res_first),
		.res_second   (res_second),
		.empty        (ob_empty),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.ring_address (ring_address),
		.last         (last)
	);

	a_read_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ssm_pkg::action_t'(action) != ssm_pkg::ACT_LOAD) |=>
		(state_q == ssm_pkg::ST_READ))
		else $error("non-load transfer did not enter read state");

	a_mul_then_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssm_pkg::ST_MUL) |=> (state_q == ssm_pkg::ST_ADD && wr_en))
		else $error("multiply not followed by write back");

	a_xfer_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssm_pkg::ST_READ && act == ssm_pkg::ACT_XFER && ob_empty) |=>
		(out_valid && state_q == ssm_pkg::ST_IDLE))
		else $error("transfer did not present a result");

	a_mono_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !two) |=> (out_valid && last))
		else $error("mono transfer result without last");

endmodule
